### rtl/core/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and codes for the sorted order-statistic store.
// ----------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_ANSWERED = 2'd1,
        ST_BAD_RANK = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [VALUE_W-1:0]  value;
        logic [RANK_W-1:0]          rank;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  result_value;
        logic [RANK_W-1:0]          stored_count;
    } out_item_t;

    // Data handed from one cell to its right neighbor.
    typedef struct packed {
        logic                       occ;
        logic                       gt;
        logic signed [VALUE_W-1:0]  value;
    } link_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                       ins_en;
        logic signed [VALUE_W-1:0]  value;
        logic [RANK_W-1:0]          rank;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/core/kss_stream_if.sv
// ----------------------------------------------------------------------------
// kss_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kss_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/kth_smallest_sorted_store.sv
// ----------------------------------------------------------------------------
// kth_smallest_sorted_store
// Sorted multiset of signed 32-bit values with insert and rank query.
//
// Items arrive on in_ch: opcode 0 inserts value (after any equal values),
// opcode 1 asks for the rank-th smallest value, counting from 1. Each item
// gives exactly one result on out_ch with status, result_value and the
// number of values held afterwards. Rank 0 or a rank above the count gives
// the invalid-rank status; an insert into a full store is dropped.
// The store is a row of STORE_DEPTH cells: on an insert every cell compares
// its value with the new one and either keeps it, takes its left neighbor's
// value or takes the new value, all in the same cycle. A query selects the
// matching cell and merges the row into one word.
// The result of an input transfer is captured in the output register;
// one item is taken per cycle while the receiver keeps up.
// When out_ch stalls the result holds and in_ch stops taking items.
// Reset empties the store at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_smallest_sorted_store
    import kss_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kss_stream_if.sink   in_ch,
    kss_stream_if.source out_ch
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);

    in_item_t                  in_item;
    logic                      in_ready;
    logic                      accept;
    logic                      full;
    logic                      rank_ok;
    logic                      do_insert;
    cell_cmd_t                 cmd;
    link_t                     link [STORE_DEPTH+1];
    logic signed [VALUE_W-1:0] read_values [STORE_DEPTH];
    logic signed [VALUE_W-1:0] merged;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W+RANK_W-1:0]   count_ext;
    logic                      out_valid_reg;
    out_item_t                 out_reg;
    out_item_t                 out_next;

    assign in_item  = in_ch.payload;
    assign in_ready = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    assign full      = count_reg == DEPTH_C;
    assign do_insert = accept && (in_item.opcode == OP_INSERT) && !full;
    assign rank_ok   = (in_item.rank != '0)
                    && ({{CNT_W{1'b0}}, in_item.rank}
                        <= {{RANK_W{1'b0}}, count_reg});

    assign cmd.ins_en = do_insert;
    assign cmd.value  = in_item.value;
    assign cmd.rank   = in_item.rank;

    assign link[0].occ   = 1'b1;
    assign link[0].gt    = 1'b0;
    assign link[0].value = '0;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        kss_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .count      (count_reg),
            .cmd        (cmd),
            .left       (link[i]),
            .right      (link[i+1]),
            .read_value (read_values[i])
        );
    end

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            merged = merged | read_values[i];
        end
    end

    assign count_next = do_insert ? count_reg + CNT_W'(1) : count_reg;
    assign count_ext  = {{RANK_W{1'b0}}, count_next};

    always_comb
    begin
        out_next.stored_count = count_ext[RANK_W-1:0];
        out_next.result_value = '0;
        if (in_item.opcode == OP_INSERT)
        begin
            out_next.status = full ? ST_FULL : ST_INSERTED;
        end
        else if (rank_ok)
        begin
            out_next.status       = ST_ANSWERED;
            out_next.result_value = merged;
        end
        else
        begin
            out_next.status = ST_BAD_RANK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_ready)
            begin
                out_valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

endmodule

`default_nettype wire

### rtl/core/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell
// One position of the sorted chain: holds a value, shifts right on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_cell
    import kss_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                       clk,
    input  wire logic [CNT_W-1:0]           count,
    input  wire cell_cmd_t                  cmd,
    input  wire link_t                      left,
    output link_t                           right,
    output logic signed [VALUE_W-1:0]       read_value
);

    localparam logic [CNT_W:0]          IDX = (CNT_W+1)'(INDEX);
    localparam logic [CNT_W+RANK_W-1:0] POS = (CNT_W+RANK_W)'(INDEX + 1);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      occ;
    logic                      gt;
    logic                      take_new;
    logic                      hit;

    assign occ      = {1'b0, count} > IDX;
    assign gt       = occ && (value_reg > cmd.value);
    assign take_new = left.occ && !left.gt && (gt || !occ);
    assign hit      = {{CNT_W{1'b0}}, cmd.rank} == POS;

    assign right.occ   = occ;
    assign right.gt    = gt;
    assign right.value = value_reg;

    assign read_value = hit ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_en)
        begin
            if (left.gt)
            begin
                value_next = left.value;
            end
            else if (take_new)
            begin
                value_next = cmd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted order-statistic store.
//
// A directed burst probes the empty store, the value extremes, equal values
// and out-of-range ranks. A random stream follows that fills the store to
// capacity between rank queries and then keeps querying and overflowing it.
// A shadow sorted array predicts every result, and each output transfer is
// compared field by field in order. Both channels idle in random bursts, and
// the receiver holds off once for a long stretch to back the store up.
// ----------------------------------------------------------------------------
module tb;
    import kss_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int HALF_PERIOD = 1;
    localparam int STALL_LIMIT = 4000;
    localparam int CALM_TAIL   = 120;
    localparam int RANDOM_ITEMS = 930;

    logic clk;
    logic rst_n;

    kss_stream_if #(.payload_t(in_item_t))  in_ch ();
    kss_stream_if #(.payload_t(out_item_t)) out_ch ();

    kth_smallest_sorted_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    in_item_t                 pending_items[$];
    out_item_t                rank_results_q[$];
    logic signed [VALUE_W-1:0] shadow_vals[STORE_DEPTH];
    int                       shadow_count = 0;
    int                       planned_count = 0;
    int                       total_items = 0;
    int                       accepted_items = 0;
    int                       results_seen = 0;
    int                       fail_count = 0;
    int                       send_gap = 0;
    int                       recv_hold = 0;
    int                       quiet_cycles = 0;
    bit                       in_took = 1'b0;
    bit                       pressure_done = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    function automatic out_item_t expected_rank_result(in_item_t item);
        out_item_t r;
        int        pos;
        r = '0;
        if (item.opcode == OP_INSERT)
        begin
            if (shadow_count >= STORE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_vals[i] > item.value)
                        pos = i;
                for (int i = shadow_count; i > pos; i--)
                    shadow_vals[i] = shadow_vals[i - 1];
                shadow_vals[pos] = item.value;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end
        else if (item.rank == 0 || int'(item.rank) > shadow_count)
        begin
            r.status = ST_BAD_RANK;
        end
        else
        begin
            r.status       = ST_ANSWERED;
            r.result_value = shadow_vals[item.rank - 1];
        end
        r.stored_count = shadow_count[RANK_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2: v = $signed($urandom_range(0, 16)) - 32'sd8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic push_insert(logic signed [VALUE_W-1:0] v);
        in_item_t item;
        item.opcode = OP_INSERT;
        item.value  = v;
        item.rank   = RANK_W'($urandom_range(0, 127));
        pending_items.insert(pending_items.size(), item);
        if (planned_count < STORE_DEPTH)
            planned_count++;
    endtask

    task automatic push_query(int k);
        in_item_t item;
        item.opcode = OP_QUERY;
        item.value  = $urandom;
        item.rank   = k[RANK_W-1:0];
        pending_items.insert(pending_items.size(), item);
    endtask

    task automatic note_mismatch(string what, out_item_t want, out_item_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected status %0d value %0d count %0d, %s %0d value %0d count %0d",
                     what, want.status, want.result_value, want.stored_count,
                     "got status", got.status, got.result_value, got.stored_count);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        in_took = rst_n && in_ch.valid && in_ch.ready;
        if (in_took)
        begin
            rank_results_q.insert(rank_results_q.size(),
                                  expected_rank_result(in_ch.payload));
            accepted_items++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (rank_results_q.size() == 0)
            begin
                note_mismatch("unexpected result", '0, out_ch.payload);
            end
            else
            begin
                want = rank_results_q.pop_front();
                if (out_ch.payload.status != want.status
                        || out_ch.payload.result_value != want.result_value
                        || out_ch.payload.stored_count != want.stored_count)
                    note_mismatch("result mismatch", want, out_ch.payload);
            end
        end
    end

    // hold valid and payload until the transfer completes
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (accepted_items < total_items - CALM_TAIL
                     && (accepted_items / 100) % 3 != 2
                     && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(1, 17) - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.payload <= pending_items.pop_front();
                in_ch.valid   <= 1'b1;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!pressure_done && results_seen >= 300)
            begin
                pressure_done = 1'b1;
                recv_hold = 199;
                out_ch.ready <= 1'b0;
            end
            else if (recv_hold > 0)
            begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (accepted_items < total_items - CALM_TAIL
                     && (results_seen / 128) % 3 != 1
                     && $urandom_range(0, 5) == 0)
            begin
                recv_hold = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;

        push_query(0);
        push_query(1);
        push_insert(32'sh8000_0000);
        push_insert(32'sh7FFF_FFFF);
        push_insert('0);
        push_insert(-32'sd1);
        push_insert('0);
        push_insert(32'sd1);
        for (int k = 1; k <= 7; k++)
            push_query(k);
        push_query(127);
        push_query(STORE_DEPTH);

        // grow the store slowly, then keep querying and overflowing it
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((planned_count < STORE_DEPTH && $urandom_range(0, 6) == 0)
                    || (planned_count >= STORE_DEPTH && $urandom_range(0, 3) == 0))
            begin
                push_insert(pick_value());
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: push_query(0);
                    1: push_query($urandom_range(0, 127));
                    2: push_query(planned_count + 1);
                    3: push_query(planned_count);
                    default: push_query($urandom_range(1, planned_count > 0 ? planned_count : 1));
                endcase
            end
        end
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_items < total_items || rank_results_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
rtl/core/kss_pkg.sv
rtl/core/kss_stream_if.sv
rtl/core/kss_cell.sv
rtl/core/kth_smallest_sorted_store.sv
tb/tb.sv
